FILE: hdl/low_power_timer_single_shot_assert.svh
// Assertion macros used by the timer's checker file.
`ifndef LOW_POWER_TIMER_SINGLE_SHOT_ASSERT_SVH
`define LOW_POWER_TIMER_SINGLE_SHOT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPTSS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lptss assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LPTSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lptss assertion failed: next-cycle implication");

`endif

FILE: hdl/lptss_pkg.sv
// Types, constants and register map of the low-power single-shot timer.
package lptss_pkg;

   // Accumulator and arithmetic widths.
   localparam int AccWidth      = 48;
   localparam int HzWidth       = 27;
   localparam int CyclesWidth   = 16;
   localparam int PreWidth      = 3;
   localparam int DenWidth      = HzWidth + (1 << PreWidth) - 1;
   localparam int ProdWidth     = HzWidth + CyclesWidth;
   localparam int CntWidth      = 16;
   localparam int CtrlWidth     = 5;
   localparam int WordWidth     = 32;
   localparam int OffWidth      = 10;
   localparam int DivCntWidth   = $clog2(AccWidth);
   localparam int CsrIndexWidth = 1;

   // Commands.
   localparam logic [1:0] CmdRead  = 2'd0;
   localparam logic [1:0] CmdWrite = 2'd1;
   localparam logic [1:0] CmdTick  = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrCpuHz = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrSrcHz = 1'b1;

   // Register offsets.
   localparam logic [OffWidth-1:0] OffIsr  = 10'h000;
   localparam logic [OffWidth-1:0] OffIcr  = 10'h004;
   localparam logic [OffWidth-1:0] OffIer  = 10'h008;
   localparam logic [OffWidth-1:0] OffCfgr = 10'h00C;
   localparam logic [OffWidth-1:0] OffCr   = 10'h010;
   localparam logic [OffWidth-1:0] OffArr  = 10'h018;
   localparam logic [OffWidth-1:0] OffCnt  = 10'h01C;

   localparam logic [2:0] AccessWord = 3'd4;

   // Register fields.
   localparam logic [CtrlWidth-1:0] CtrlMask = 5'h13;
   localparam int CtrlEnBit     = 0;
   localparam int CtrlSstartBit = 1;
   localparam int CtrlRorBit    = 4;
   localparam int IcrClrBit     = 1;
   localparam int IerBit        = 1;
   localparam int IsrBit        = 1;
   localparam int PreLsb        = 9;

   // Reset values.
   localparam logic [CntWidth-1:0] ReloadReset = 16'hFFFF;
   localparam logic [HzWidth-1:0]  CpuHzReset  = 27'd24000000;
   localparam logic [HzWidth-1:0]  SrcHzReset  = 27'd32768;

   // One input item.
   typedef struct packed {
      logic [1:0]             cmd;
      logic                   bus_clock_on;
      logic [OffWidth-1:0]    reg_offset;
      logic [2:0]             access_size;
      logic [WordWidth-1:0]   write_data;
      logic [CyclesWidth-1:0] elapsed_cycles;
   } req_type;

   // One result item.
   typedef struct packed {
      logic                 accepted;
      logic [WordWidth-1:0] read_data;
      logic                 irq_pulse;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_item;
      logic start_mul;
      logic start_div;
      logic div_step;
      logic commit_bus;
      logic commit_tick;
   } lptss_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic tick_run;
   } lptss_status_type;

endpackage

FILE: hdl/lptss_datapath.sv
// Datapath: registers, bus decode, multiplier and restoring divider.
module lptss_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lptss_pkg::req_type                 req_data,
   input  logic                               csr_we,
   input  logic [lptss_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lptss_pkg::HzWidth-1:0]      csr_wdata,
   input  lptss_pkg::lptss_cmd_type           cmd,
   output lptss_pkg::lptss_status_type        status,
   output lptss_pkg::rsp_type                 rsp_data
);
   import lptss_pkg::*;

   // Configuration and architectural state.
   logic [HzWidth-1:0]   cpu_hz_ff, src_hz_ff;
   logic                 match_ff, match_in;
   logic                 irqen_ff, irqen_in;
   logic [WordWidth-1:0] cfg_ff, cfg_in;
   logic [CtrlWidth-1:0] ctrl_ff, ctrl_in;
   logic [CntWidth-1:0]  reload_ff, reload_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [AccWidth-1:0]  acc_ff, acc_in;

   // Work registers for one item.
   req_type              item_ff;
   logic [ProdWidth-1:0] prod_ff;
   logic [AccWidth-1:0]  quo_ff, quo_in;
   logic [DenWidth-1:0]  rem_ff, rem_in;
   logic [DenWidth-1:0]  den_ff;
   rsp_type              rsp_ff, rsp_in;

   // Bus decode signals.
   logic                 bus_ok;
   logic                 rd_hit, wr_hit;
   logic [WordWidth-1:0] rd_value;

   // Divider step signals.
   logic [DenWidth:0]    trial;
   logic [DenWidth:0]    diff;
   logic                 ge;

   // Tick result signals.
   logic [CntWidth-1:0]  room;
   logic                 overflow;
   logic [PreWidth-1:0]  prescale;

   assign prescale = cfg_ff[PreLsb +: PreWidth];
   assign bus_ok   = item_ff.bus_clock_on && (item_ff.access_size == AccessWord);

   assign status.tick_run = (item_ff.cmd == CmdTick) && item_ff.bus_clock_on &&
                            ctrl_ff[CtrlEnBit] && ctrl_ff[CtrlSstartBit] &&
                            (cpu_hz_ff != '0) && (src_hz_ff != '0);

   // Read decode of the register window.
   always_comb begin
      rd_hit   = 1'b1;
      rd_value = '0;
      case (item_ff.reg_offset)
         OffIsr:  rd_value[IsrBit] = match_ff;
         OffIcr:  rd_value = '0;
         OffIer:  rd_value[IerBit] = irqen_ff;
         OffCfgr: rd_value = cfg_ff;
         OffCr:   rd_value = WordWidth'(ctrl_ff);
         OffArr:  rd_value = WordWidth'(reload_ff);
         OffCnt:  rd_value = WordWidth'(count_ff);
         default: rd_hit = 1'b0;
      endcase
   end

   // Write offsets that exist.
   always_comb begin
      case (item_ff.reg_offset)
         OffIcr, OffIer, OffCfgr, OffCr, OffArr: wr_hit = 1'b1;
         default:                                wr_hit = 1'b0;
      endcase
   end

   // One restoring division step: shift in the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[AccWidth-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = !diff[DenWidth];

   // Room left before the reload value, and whether the quotient goes past it.
   assign room     = (count_ff < reload_ff) ? (reload_ff - count_ff) : '0;
   assign overflow = (|quo_ff[AccWidth-1:CntWidth]) || (quo_ff[CntWidth-1:0] > room);

   // Next-state logic for the datapath registers.
   always_comb begin
      match_in  = match_ff;
      irqen_in  = irqen_ff;
      cfg_in    = cfg_ff;
      ctrl_in   = ctrl_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      rsp_in    = rsp_ff;

      if (cmd.start_div) begin
         quo_in = acc_ff + AccWidth'(prod_ff);
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[AccWidth-2:0], ge};
         rem_in = ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
      end

      if (cmd.commit_bus) begin
         rsp_in = '0;
         if (item_ff.cmd == CmdRead && bus_ok && rd_hit) begin
            rsp_in.accepted  = 1'b1;
            rsp_in.read_data = rd_value;
            if (item_ff.reg_offset == OffCnt && ctrl_ff[CtrlRorBit]) begin
               count_in = '0;
            end
         end else if (item_ff.cmd == CmdWrite && bus_ok && wr_hit) begin
            rsp_in.accepted = 1'b1;
            case (item_ff.reg_offset)
               OffIcr: begin
                  if (item_ff.write_data[IcrClrBit]) begin
                     match_in = 1'b0;
                  end
               end
               OffIer:  irqen_in = item_ff.write_data[IerBit];
               OffCfgr: cfg_in = item_ff.write_data;
               OffCr: begin
                  if (!item_ff.write_data[CtrlEnBit]) begin
                     count_in = '0;
                     acc_in   = '0;
                  end
                  ctrl_in = item_ff.write_data[CtrlWidth-1:0] & CtrlMask;
               end
               OffArr:  reload_in = item_ff.write_data[CntWidth-1:0];
               default: rsp_in.accepted = 1'b0;
            endcase
         end
      end

      if (cmd.commit_tick) begin
         rsp_in = '0;
         acc_in = AccWidth'(rem_ff);
         if (overflow) begin
            count_in               = '0;
            match_in               = 1'b1;
            ctrl_in[CtrlSstartBit] = 1'b0;
            rsp_in.irq_pulse       = irqen_ff;
         end else begin
            count_in = count_ff + quo_ff[CntWidth-1:0];
         end
      end
   end

   // Configuration and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_hz_ff <= CpuHzReset;
         src_hz_ff <= SrcHzReset;
         match_ff  <= 1'b0;
         irqen_ff  <= 1'b0;
         cfg_ff    <= '0;
         ctrl_ff   <= '0;
         reload_ff <= ReloadReset;
         count_ff  <= '0;
         acc_ff    <= '0;
      end else begin
         if (csr_we && csr_index == CsrCpuHz) begin
            cpu_hz_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CsrSrcHz) begin
            src_hz_ff <= csr_wdata;
         end
         match_ff  <= match_in;
         irqen_ff  <= irqen_in;
         cfg_ff    <= cfg_in;
         ctrl_ff   <= ctrl_in;
         reload_ff <= reload_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
      end
   end

   // Payload registers: item, product, divider and result.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.start_mul) begin
         prod_ff <= ProdWidth'(item_ff.elapsed_cycles) * ProdWidth'(src_hz_ff);
      end
      if (cmd.start_div) begin
         den_ff <= DenWidth'(cpu_hz_ff) << prescale;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/lptss_ctrl.sv
// Controller: sequences each item and owns the result valid flag.
module lptss_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  lptss_pkg::lptss_status_type status,
   output lptss_pkg::lptss_cmd_type    cmd
);
   import lptss_pkg::*;

   typedef enum logic [5:0] {
      StIdle = 6'b000001,
      StExec = 6'b000010,
      StAdd  = 6'b000100,
      StDiv  = 6'b001000,
      StDone = 6'b010000,
      StHold = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [DivCntWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of one item.
   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = StExec;
            end
         end
         StExec: begin
            if (status.tick_run) begin
               cmd.start_mul = 1'b1;
               state_in      = StAdd;
            end else if (out_free) begin
               cmd.commit_bus = 1'b1;
               state_in       = StIdle;
            end else begin
               state_in = StHold;
            end
         end
         StHold: begin
            if (out_free) begin
               cmd.commit_bus = 1'b1;
               state_in       = StIdle;
            end
         end
         StAdd: begin
            cmd.start_div = 1'b1;
            bit_cnt_in    = '0;
            state_in      = StDiv;
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == DivCntWidth'(AccWidth - 1)) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (out_free) begin
               cmd.commit_tick = 1'b1;
               state_in        = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.commit_bus || cmd.commit_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/low_power_timer_single_shot.sv
// Low-power single-shot timer: a register window that is read and written by bus
// transfers and advanced by tick transfers. A bus access, a refused access and a
// tick that finds the timer stopped have their result registered when the
// execute or hold state commits it, then the block returns to idle for the next
// transfer. A running tick has its result registered after the cycles-times-frequency
// multiply, the accumulator add, the restoring divider with one quotient bit per
// cycle over the 48-bit accumulator, and the commit; it then returns to idle.
// The result sits in an output register, so the next transfer is taken while it
// waits; an item that finishes while that register still holds an unaccepted
// result waits for as long as the result side stalls.
// Both clock frequency registers are written on the csr_ port.
module low_power_timer_single_shot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lptss_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lptss_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [lptss_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lptss_pkg::HzWidth-1:0]       csr_wdata
);
   import lptss_pkg::*;

   lptss_cmd_type    cmd;
   lptss_status_type status;

   // Sequencer.
   lptss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers and arithmetic.
   lptss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/lptss_checker.sv
// Port-level checks of the timer, bound to its top level.
`include "low_power_timer_single_shot_assert.svh"

module lptss_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input lptss_pkg::rsp_type rsp_data
);
   import lptss_pkg::*;

   // A stalled result holds its value.
   `LPTSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // One item at a time: the block is busy right after a transfer in.
   `LPTSS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // Read data only comes with an accepted access.
   `LPTSS_ASSERT_NOW(a_rdata_needs_acc, clock, reset, rsp_valid && !rsp_data.accepted, rsp_data.read_data == '0)

   // An interrupt pulse only comes from a tick, never from a bus access.
   `LPTSS_ASSERT_NOW(a_irq_not_bus, clock, reset, rsp_valid && rsp_data.irq_pulse, !rsp_data.accepted)

   // Reset leaves no result pending.
   `LPTSS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind low_power_timer_single_shot lptss_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
